// ===== src/gait_step_and_freeze_detector_assert.svh =====
// Assertion macros shared by the gait detector RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef GAIT_STEP_AND_FREEZE_DETECTOR_ASSERT_SVH
`define GAIT_STEP_AND_FREEZE_DETECTOR_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define GSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define GSFD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== src/gsfd_pkg.sv =====
// Package for the gait step and freeze detector: widths, codes, reset values
// and the structs passed between front, back, queues and top. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gsfd_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned MagW      = 16;
  localparam int unsigned SumW      = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned StepW     = 16;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [1:0] {
    MODE_START      = 2'd0,
    MODE_STATIONARY = 2'd1,
    MODE_WALKING    = 2'd2,
    MODE_FREEZING   = 2'd3
  } gait_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ONE_G_LEVEL    = 3'd0,
    REG_STEP_THRESHOLD = 3'd1,
    REG_MIN_STEP_GAP   = 3'd2,
    REG_FREEZE_GAP     = 3'd3,
    REG_CADENCE_FACTOR = 3'd4
  } cfg_reg_e;

  localparam logic [CfgW-1:0] OneGLevelRst     = 16'd16393;
  localparam logic [CfgW-1:0] StepThresholdRst = 16'd3279;
  localparam logic [CfgW-1:0] MinStepGapRst    = 16'd26;
  localparam logic [CfgW-1:0] FreezeGapRst     = 16'd104;
  localparam logic [CfgW-1:0] CadenceFactorRst = 16'd156;

  typedef struct packed {
    logic [CfgW-1:0] one_g_level;
    logic [CfgW-1:0] step_threshold;
    logic [CfgW-1:0] min_step_gap;
    logic [CfgW-1:0] freeze_gap;
    logic [CfgW-1:0] cadence_factor;
  } gsfd_cfg_t;

  typedef struct packed {
    logic             step_found;
    gait_mode_e       gait_mode;
    logic [StepW-1:0] steps_so_far;
    logic             freeze_began;
    logic             freeze_ended;
  } gsfd_res_t;

  localparam int unsigned ResW = $bits(gsfd_res_t);

endpackage

`default_nettype wire

// ===== src/gsfd_fifo.sv =====
// Small register FIFO used for the magnitude queue and the result queue.
// Depends on the assertion header only.
`timescale 1ns / 1ps
`default_nettype none
`include "gait_step_and_freeze_detector_assert.svh"

module gsfd_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `GSFD_ASSERT(a_count_bound, (count_q <= CntW'(Depth)), "fifo count beyond depth")
  `GSFD_ASSERT(a_push_grows, (do_push && !do_pop |=> count_q == $past(count_q) + 1'b1), "fifo lost a word")

endmodule

`default_nettype wire

// ===== src/gsfd_front.sv =====
// Front end: takes a sample, sums the squared axes with one multiplier and
// takes the integer square root one bit pair a cycle. Uses gsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "gait_step_and_freeze_detector_assert.svh"

module gsfd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic signed [gsfd_pkg::SampleW-1:0] accel_x_i,
  input  logic signed [gsfd_pkg::SampleW-1:0] accel_y_i,
  input  logic signed [gsfd_pkg::SampleW-1:0] accel_z_i,
  output logic                              mag_valid_o,
  input  logic                              mag_ready_i,
  output logic [gsfd_pkg::MagW-1:0]         mag_o
);
  import gsfd_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_SQUARE = 4'b0010,
    F_ROOT   = 4'b0100,
    F_PUSH   = 4'b1000
  } front_state_e;

  localparam int unsigned AxisCnt = 3;
  localparam int unsigned AxisW   = $clog2(AxisCnt);
  localparam logic [AxisW-1:0] AxisLast = AxisW'(AxisCnt - 1);
  localparam logic [SumW-1:0]  RootTop  = SumW'(1) << (SumW - 2);

  function automatic logic [SampleW-1:0] abs_raw(input logic signed [SampleW-1:0] v);
    abs_raw = v[SampleW-1] ? (SampleW'(~v) + SampleW'(1)) : SampleW'(v);
  endfunction

  front_state_e     state_q, state_d;
  logic [AxisW-1:0] axis_q;
  logic [SampleW-1:0] abs_q [AxisCnt];
  logic [SumW-1:0]  rem_q, root_q, bit_q;
  logic [SumW-1:0]  square, trial;

  assign full_o      = (state_q != F_IDLE);
  assign mag_valid_o = (state_q == F_PUSH);
  assign mag_o       = root_q[MagW-1:0];
  assign square      = SumW'(abs_q[0]) * SumW'(abs_q[0]);
  assign trial       = root_q + bit_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:   if (push_i) state_d = F_SQUARE;
      F_SQUARE: if (axis_q == AxisLast) state_d = F_ROOT;
      F_ROOT:   if (bit_q[0]) state_d = F_PUSH;
      F_PUSH:   if (mag_ready_i) state_d = F_IDLE;
      default:  state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_SQUARE) begin
        axis_q <= (axis_q == AxisLast) ? '0 : axis_q + 1'b1;
      end
    end
  end

  // Datapath: operand shift line, running sum, then restoring root.
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && push_i) begin
      abs_q[0] <= abs_raw(accel_x_i);
      abs_q[1] <= abs_raw(accel_y_i);
      abs_q[2] <= abs_raw(accel_z_i);
      rem_q    <= '0;
    end
    if (state_q == F_SQUARE) begin
      rem_q <= rem_q + square;
      for (int i = 0; i < AxisCnt - 1; i++) begin
        abs_q[i] <= abs_q[i+1];
      end
      if (axis_q == AxisLast) begin
        root_q <= '0;
        bit_q  <= RootTop;
      end
    end
    if (state_q == F_ROOT) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  `GSFD_ASSERT(a_root_fits, (state_q == F_PUSH |-> root_q[SumW-1:MagW] == '0), "root wider than magnitude")

endmodule

`default_nettype wire

// ===== src/gsfd_back.sv =====
// Back end: step signal, peak detector, cadence product and gait mode
// machine, one magnitude word at a time. Uses gsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "gait_step_and_freeze_detector_assert.svh"

module gsfd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gsfd_pkg::gsfd_cfg_t       cfg_i,
  input  logic                      mag_valid_i,
  input  logic [gsfd_pkg::MagW-1:0] mag_i,
  output logic                      mag_pop_o,
  input  logic                      res_ready_i,
  output logic                      res_push_o,
  output gsfd_pkg::gsfd_res_t       res_o
);
  import gsfd_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_SIG  = 5'b00010,
    B_DET  = 5'b00100,
    B_MUL  = 5'b01000,
    B_MODE = 5'b10000
  } back_state_e;

  back_state_e        state_q, state_d;
  gait_mode_e         mode_q, mode_d;
  logic [MagW-1:0]    prev_q, peak_q;
  logic               rising_q;
  logic [CountW-1:0]  sample_count_q, last_step_q;
  logic [StepW-1:0]   step_count_q;
  logic [MagW-1:0]    mag_q, sig_q;
  logic               step_q;
  logic [CountW-1:0]  prod_q, since_q;
  logic               began, ended, clear_steps;
  logic               step_ok;

  assign mag_pop_o  = (state_q == B_IDLE) && mag_valid_i && res_ready_i;
  assign res_push_o = (state_q == B_MODE);

  assign step_ok = (peak_q > cfg_i.step_threshold) &&
                   ((sample_count_q - last_step_q) > CountW'(cfg_i.min_step_gap));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (mag_pop_o) state_d = B_SIG;
      B_SIG:   state_d = B_DET;
      B_DET:   state_d = B_MUL;
      B_MUL:   state_d = B_MODE;
      B_MODE:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    began       = 1'b0;
    ended       = 1'b0;
    clear_steps = 1'b0;
    unique case (mode_q)
      MODE_START:      mode_d = MODE_STATIONARY;
      MODE_STATIONARY: if (step_q && prod_q > sample_count_q) mode_d = MODE_WALKING;
      MODE_WALKING: begin
        if (since_q > CountW'(cfg_i.freeze_gap)) begin
          mode_d = MODE_FREEZING;
          began  = 1'b1;
        end
      end
      MODE_FREEZING: begin
        clear_steps = 1'b1;
        if (step_q) begin
          mode_d = MODE_WALKING;
          ended  = 1'b1;
        end
      end
      default: mode_d = MODE_START;
    endcase
  end

  always_comb begin
    res_o.step_found   = step_q;
    res_o.gait_mode    = mode_d;
    res_o.steps_so_far = clear_steps ? '0 : step_count_q;
    res_o.freeze_began = began;
    res_o.freeze_ended = ended;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      mode_q         <= MODE_START;
      prev_q         <= '0;
      peak_q         <= '0;
      rising_q       <= 1'b0;
      sample_count_q <= '0;
      last_step_q    <= '0;
      step_count_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_SIG && sample_count_q != '1) begin
        sample_count_q <= sample_count_q + 1'b1;
      end
      if (state_q == B_DET) begin
        if (sig_q > prev_q) begin
          rising_q <= 1'b1;
          if (sig_q > peak_q) peak_q <= sig_q;
        end else if (rising_q && sig_q < prev_q) begin
          rising_q <= 1'b0;
          peak_q   <= '0;
          if (step_ok) begin
            if (step_count_q != '1) step_count_q <= step_count_q + 1'b1;
            last_step_q <= sample_count_q;
          end
        end
        prev_q <= sig_q;
      end
      if (state_q == B_MODE) begin
        mode_q <= mode_d;
        if (clear_steps) step_count_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mag_pop_o) begin
      mag_q <= mag_i;
    end
    if (state_q == B_SIG) begin
      sig_q <= (mag_q >= cfg_i.one_g_level) ? (mag_q - cfg_i.one_g_level)
                                            : (cfg_i.one_g_level - mag_q);
    end
    if (state_q == B_DET) begin
      step_q <= (sig_q <= prev_q) && rising_q && (sig_q < prev_q) && step_ok;
    end
    if (state_q == B_MUL) begin
      prod_q  <= CountW'(step_count_q) * CountW'(cfg_i.cadence_factor);
      since_q <= sample_count_q - last_step_q;
    end
  end

  `GSFD_ASSERT(a_step_marks_sample, (state_q == B_MODE && step_q |-> last_step_q == sample_count_q), "step not stamped")
  `GSFD_ASSERT_NEVER(a_freeze_flags, (res_push_o && res_o.freeze_began && res_o.freeze_ended), "freeze began and ended together")

endmodule

`default_nettype wire

// ===== src/gait_step_and_freeze_detector.sv =====
// Top level of the gait step and freeze detector: configuration registers,
// front end, magnitude queue, back end and result queue.
// Depends on gsfd_pkg, gsfd_front, gsfd_fifo and gsfd_back.
//
//   channel   handshake                 payload
//   --------  ------------------------  ----------------------------------------
//   sample    push / full               accel_x_i, accel_y_i, accel_z_i
//   result    empty / pop               step_found_o, gait_mode_o, steps_so_far_o,
//                                       freeze_began_o, freeze_ended_o
//   config    valid / ready             cfg_index_i, cfg_data_i
//
// A sample passes through the shared squaring multiplier, the bit-pair square
// root and a hand-off state that waits while the magnitude queue is full;
// full stays high for that time, so a new word goes in only once the last
// has been handed on. The back end runs alongside, one word at a time.
// Reset is asynchronous, active low; it loads the register defaults and the
// start mode. A stalled result queue fills the magnitude queue, then holds
// the front end; configuration writes are always taken (ready is tied high).
`timescale 1ns / 1ps
`default_nettype none

module gait_step_and_freeze_detector #(
  parameter int unsigned MidDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample words
  input  logic                                push,
  output logic                                full,
  input  logic signed [gsfd_pkg::SampleW-1:0] accel_x_i,
  input  logic signed [gsfd_pkg::SampleW-1:0] accel_y_i,
  input  logic signed [gsfd_pkg::SampleW-1:0] accel_z_i,
  // configuration writes
  input  logic                                valid,
  output logic                                ready,
  input  logic [gsfd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gsfd_pkg::CfgW-1:0]           cfg_data_i,
  // result words
  output logic                                empty,
  input  logic                                pop,
  output logic                                step_found_o,
  output logic [1:0]                          gait_mode_o,
  output logic [gsfd_pkg::StepW-1:0]          steps_so_far_o,
  output logic                                freeze_began_o,
  output logic                                freeze_ended_o
);
  import gsfd_pkg::*;

  gsfd_cfg_t       cfg_q;
  logic            mag_valid, mag_ready, mid_full, mid_empty, mag_pop;
  logic [MagW-1:0] front_mag, mid_mag;
  logic            res_push, out_full;
  gsfd_res_t       back_res, out_res;
  logic [ResW-1:0] out_data;

  // Register writes never stall; no backpressure needed.
  assign ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_g_level    <= OneGLevelRst;
      cfg_q.step_threshold <= StepThresholdRst;
      cfg_q.min_step_gap   <= MinStepGapRst;
      cfg_q.freeze_gap     <= FreezeGapRst;
      cfg_q.cadence_factor <= CadenceFactorRst;
    end else if (valid && ready) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ONE_G_LEVEL:    cfg_q.one_g_level    <= cfg_data_i;
        REG_STEP_THRESHOLD: cfg_q.step_threshold <= cfg_data_i;
        REG_MIN_STEP_GAP:   cfg_q.min_step_gap   <= cfg_data_i;
        REG_FREEZE_GAP:     cfg_q.freeze_gap     <= cfg_data_i;
        REG_CADENCE_FACTOR: cfg_q.cadence_factor <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // Front: magnitude of each sample.
  gsfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .accel_x_i   (accel_x_i),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .mag_valid_o (mag_valid),
    .mag_ready_i (mag_ready),
    .mag_o       (front_mag)
  );

  assign mag_ready = !mid_full;

  // Decouples the root unit from the detector.
  gsfd_fifo #(
    .Width (MagW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mag_valid),
    .full_o  (mid_full),
    .data_i  (front_mag),
    .pop_i   (mag_pop),
    .empty_o (mid_empty),
    .data_o  (mid_mag)
  );

  // Back: step detection and gait mode.
  gsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mag_valid_i (!mid_empty),
    .mag_i       (mid_mag),
    .mag_pop_o   (mag_pop),
    .res_ready_i (!out_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Result queue: the back end only starts a word when a slot is free.
  gsfd_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (out_full),
    .data_i  (back_res),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_data)
  );

  assign out_res        = gsfd_res_t'(out_data);
  assign step_found_o   = out_res.step_found;
  assign gait_mode_o    = out_res.gait_mode;
  assign steps_so_far_o = out_res.steps_so_far;
  assign freeze_began_o = out_res.freeze_began;
  assign freeze_ended_o = out_res.freeze_ended;

endmodule

`default_nettype wire

// ===== tb/sv/gait_result_checker.sv =====
// Result checker for the gait step and freeze detector: watches the sample,
// config and result channels, predicts each result word and compares it.
// Depends on gsfd_pkg.
`timescale 1ns / 1ps

module gait_result_checker
  import gsfd_pkg::*;
#(
  parameter int unsigned MaxReports = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic signed [SampleW-1:0] accel_x_i,
  input  logic signed [SampleW-1:0] accel_y_i,
  input  logic signed [SampleW-1:0] accel_z_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic                      step_found_i,
  input  logic [1:0]                gait_mode_i,
  input  logic [StepW-1:0]          steps_so_far_i,
  input  logic                      freeze_began_i,
  input  logic                      freeze_ended_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  gsfd_cfg_t         cfg;
  gait_mode_e        cur_mode;
  logic [MagW-1:0]   last_sig;
  logic [MagW-1:0]   rise_peak;
  logic              rising;
  logic [CountW-1:0] n_samples;
  logic [CountW-1:0] step_at;
  logic [StepW-1:0]  n_steps;
  gsfd_res_t         expected_words[$];
  int unsigned       n_results;

  // Floor square root, one result bit per pass from the top.
  function automatic logic [MagW-1:0] floor_sqrt(input logic [SumW-1:0] v);
    logic [MagW-1:0] r;
    logic [MagW-1:0] t;
    r = '0;
    for (int b = MagW - 1; b >= 0; b--) begin
      t = r | (MagW'(1) << b);
      if (32'(t) * 32'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic gsfd_res_t predict_gait_word(input logic signed [SampleW-1:0] x,
                                                  input logic signed [SampleW-1:0] y,
                                                  input logic signed [SampleW-1:0] z);
    gsfd_res_t         w;
    longint            ax;
    longint            ay;
    longint            az;
    logic [SumW-1:0]   energy;
    logic [MagW-1:0]   mag;
    logic [MagW-1:0]   sig;
    logic [CountW-1:0] since;
    logic              found;
    ax = x;
    ay = y;
    az = z;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    energy = SumW'(ax * ax + ay * ay + az * az);
    mag = floor_sqrt(energy);
    w = '0;
    found = 1'b0;

    if (n_samples != '1) n_samples = n_samples + 1'b1;
    sig = (mag >= cfg.one_g_level) ? mag - cfg.one_g_level : cfg.one_g_level - mag;

    // end of a rise is where a step may count
    if (sig > last_sig) begin
      rising = 1'b1;
      if (sig > rise_peak) rise_peak = sig;
    end else if (rising && sig < last_sig) begin
      rising = 1'b0;
      if (rise_peak > cfg.step_threshold &&
          (n_samples - step_at) > CountW'(cfg.min_step_gap)) begin
        if (n_steps != '1) n_steps = n_steps + 1'b1;
        step_at = n_samples;
        found = 1'b1;
      end
      rise_peak = '0;
    end
    last_sig = sig;
    since = n_samples - step_at;

    case (cur_mode)
      MODE_START: cur_mode = MODE_STATIONARY;
      MODE_STATIONARY: begin
        if (found && 64'(n_steps) * 64'(cfg.cadence_factor) > 64'(n_samples))
          cur_mode = MODE_WALKING;
      end
      MODE_WALKING: begin
        if (since > CountW'(cfg.freeze_gap)) begin
          cur_mode = MODE_FREEZING;
          w.freeze_began = 1'b1;
        end
      end
      default: begin
        n_steps = '0;
        if (found) begin
          cur_mode = MODE_WALKING;
          w.freeze_ended = 1'b1;
        end
      end
    endcase

    w.step_found   = found;
    w.gait_mode    = cur_mode;
    w.steps_so_far = n_steps;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gsfd_res_t got;
    gsfd_res_t want;
    if (!rst_ni) begin
      cfg.one_g_level    = OneGLevelRst;
      cfg.step_threshold = StepThresholdRst;
      cfg.min_step_gap   = MinStepGapRst;
      cfg.freeze_gap     = FreezeGapRst;
      cfg.cadence_factor = CadenceFactorRst;
      cur_mode  = MODE_START;
      last_sig  = '0;
      rise_peak = '0;
      rising    = 1'b0;
      n_samples = '0;
      step_at   = '0;
      n_steps   = '0;
      expected_words.delete();
      n_results    = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ONE_G_LEVEL:    cfg.one_g_level    = cfg_data_i;
          REG_STEP_THRESHOLD: cfg.step_threshold = cfg_data_i;
          REG_MIN_STEP_GAP:   cfg.min_step_gap   = cfg_data_i;
          REG_FREEZE_GAP:     cfg.freeze_gap     = cfg_data_i;
          REG_CADENCE_FACTOR: cfg.cadence_factor = cfg_data_i;
          default: ;
        endcase
      end

      if (pop_i && !empty_i) begin
        got.step_found   = step_found_i;
        got.gait_mode    = gait_mode_e'(gait_mode_i);
        got.steps_so_far = steps_so_far_i;
        got.freeze_began = freeze_began_i;
        got.freeze_ended = freeze_ended_i;
        if (expected_words.size() == 0) begin
          if (fail_count_o < MaxReports)
            $display("%0t: result word %0d arrived with nothing expected", $time, n_results);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_count_o < MaxReports)
              $display({"%0t: result word %0d mismatch: expected step %0d mode %0d ",
                        "steps %0d began %0d ended %0d, got step %0d mode %0d ",
                        "steps %0d began %0d ended %0d"}, $time, n_results,
                       want.step_found, want.gait_mode, want.steps_so_far,
                       want.freeze_began, want.freeze_ended,
                       got.step_found, got.gait_mode, got.steps_so_far,
                       got.freeze_began, got.freeze_ended);
            fail_count_o = fail_count_o + 1;
          end
        end
        n_results = n_results + 1;
      end

      if (push_i && !full_i)
        expected_words.push_back(predict_gait_word(accel_x_i, accel_y_i, accel_z_i));
      pending_o = expected_words.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the gait detector testbench: clock, reset, sample and config stimulus,
// result draining, watchdog and verdict. Depends on gsfd_pkg,
// gait_step_and_freeze_detector and gait_result_checker.
`timescale 1ns / 1ps

module testbench;
  import gsfd_pkg::*;

  localparam int unsigned IdlePct       = 18;    // chance of an idle cycle per side
  localparam int unsigned DrainCycles   = 64;    // front, back and queues, with margin
  localparam int unsigned WatchdogLimit = 4000;  // cycles with no word moving at all
  localparam int unsigned NumRegs       = 5;
  localparam int unsigned PhaseItems    = 290;
  localparam int          MaxAxis       = 32767;
  localparam int          MaxPeak       = 30000;

  logic                      clk_i     = 1'b0;
  logic                      rst_ni    = 1'b0;
  logic                      push      = 1'b0;
  logic                      full;
  logic signed [SampleW-1:0] accel_x   = '0;
  logic signed [SampleW-1:0] accel_y   = '0;
  logic signed [SampleW-1:0] accel_z   = '0;
  logic                      valid     = 1'b0;
  logic                      ready;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [CfgW-1:0]           cfg_data  = '0;
  logic                      empty;
  logic                      pop       = 1'b0;
  logic                      step_found;
  logic [1:0]                gait_mode;
  logic [StepW-1:0]          steps_so_far;
  logic                      freeze_began;
  logic                      freeze_ended;

  int unsigned fail_count;
  int unsigned pending;      // words predicted but not yet popped
  int unsigned sent = 0;     // sample words accepted so far
  int unsigned stalled = 0;  // watchdog count
  bit          calm = 1'b0;  // set for a stretch with no idling on either side
  gsfd_cfg_t   shadow_cfg;   // register values, used only to shape the stimulus

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  gait_step_and_freeze_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .valid         (valid),
    .ready         (ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .empty         (empty),
    .pop           (pop),
    .step_found_o  (step_found),
    .gait_mode_o   (gait_mode),
    .steps_so_far_o(steps_so_far),
    .freeze_began_o(freeze_began),
    .freeze_ended_o(freeze_ended)
  );

  gait_result_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .cfg_valid_i   (valid),
    .cfg_ready_i   (ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .empty_i       (empty),
    .pop_i         (pop),
    .step_found_i  (step_found),
    .gait_mode_i   (gait_mode),
    .steps_so_far_i(steps_so_far),
    .freeze_began_i(freeze_began),
    .freeze_ended_i(freeze_ended),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: pop changes on the falling edge only, stalls at random unless calm.
  always @(negedge clk_i) begin
    pop = rst_ni && (calm || $urandom_range(99, 0) >= IdlePct);
  end

  // Watchdog: any word moving on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (valid && ready)) begin
      stalled <= 0;
    end else if (stalled >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  // One sample word. Called and returns on a falling edge; full is stable
  // there and is what the next rising edge sees.
  task automatic send_sample(input logic signed [SampleW-1:0] x,
                             input logic signed [SampleW-1:0] y,
                             input logic signed [SampleW-1:0] z);
    logic ok;
    if (!calm) begin
      while ($urandom_range(99, 0) < IdlePct) begin
        push = 1'b0;
        @(negedge clk_i);
      end
    end
    push    = 1'b1;
    accel_x = x;
    accel_y = y;
    accel_z = z;
    do begin
      ok = !full;
      @(negedge clk_i);
    end while (!ok);
    sent++;
  endtask

  // Sample with roughly the given magnitude: one axis carries it with a
  // random sign, the other two carry a few counts of noise.
  task automatic send_mag(input int m);
    int                        a;
    logic signed [SampleW-1:0] v [3];
    if (m > MaxAxis) m = MaxAxis;
    if (m < 0) m = 0;
    a = $urandom_range(1, 0) ? -m : m;
    for (int k = 0; k < 3; k++) v[k] = SampleW'(int'($urandom_range(6, 0)) - 3);
    v[$urandom_range(2, 0)] = SampleW'(a);
    send_sample(v[0], v[1], v[2]);
  endtask

  // One stride: step signal climbs to peak, falls back, then sits near one g.
  // The excursion goes above or below one g at random.
  task automatic walk_stride(input int peak, input int rise, input int fall, input int quiet);
    int og;
    int dir;
    og  = shadow_cfg.one_g_level;
    dir = $urandom_range(1, 0) ? 1 : -1;
    for (int k = 1; k <= rise; k++) send_mag(og + dir * peak * k / rise);
    for (int k = fall - 1; k >= 0; k--) send_mag(og + dir * peak * k / fall);
    for (int k = 0; k < quiet; k++) send_mag(og + dir * int'($urandom_range(3, 0)));
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    logic ok;
    valid     = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do begin
      ok = ready;
      @(negedge clk_i);
    end while (!ok);
    case (idx)
      REG_ONE_G_LEVEL:    shadow_cfg.one_g_level    = data;
      REG_STEP_THRESHOLD: shadow_cfg.step_threshold = data;
      REG_MIN_STEP_GAP:   shadow_cfg.min_step_gap   = data;
      REG_FREEZE_GAP:     shadow_cfg.freeze_gap     = data;
      REG_CADENCE_FACTOR: shadow_cfg.cadence_factor = data;
      default: ;
    endcase
  endtask

  // Only called with every result word in, so the block is idle.
  task automatic set_config(input logic [CfgW-1:0] og, input logic [CfgW-1:0] thr,
                            input logic [CfgW-1:0] gap, input logic [CfgW-1:0] frz,
                            input logic [CfgW-1:0] cad);
    cfg_write(REG_ONE_G_LEVEL, og);
    cfg_write(REG_STEP_THRESHOLD, thr);
    cfg_write(REG_MIN_STEP_GAP, gap);
    cfg_write(REG_FREEZE_GAP, frz);
    cfg_write(REG_CADENCE_FACTOR, cad);
    valid = 1'b0;
  endtask

  // Index past the register list: must leave every register alone.
  task automatic write_unknown_reg();
    logic [CfgIdxW-1:0] idx;
    idx = CfgIdxW'(NumRegs + $urandom_range(2, 0));
    cfg_write(idx, CfgW'($urandom));
    valid = 1'b0;
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly strides spaced around min_step_gap so steps, walking and freezing
  // all happen; the rest is long pauses, raw noise and repeated samples.
  task automatic run_walks(input int unsigned budget);
    int unsigned               stop_at;
    int unsigned               kind;
    int                        thr;
    int                        hi;
    int                        lo;
    int                        rise;
    int                        fall;
    int                        span;
    int                        quiet;
    int                        reps;
    logic signed [SampleW-1:0] rx;
    logic signed [SampleW-1:0] ry;
    logic signed [SampleW-1:0] rz;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      kind = $urandom_range(99, 0);
      if (kind < 72) begin
        thr = shadow_cfg.step_threshold;
        hi  = thr + thr / 2 + 50;
        if (hi > MaxPeak) hi = MaxPeak;
        lo = thr / 2;
        if (lo > hi) lo = hi;
        rise = $urandom_range(4, 1);
        fall = $urandom_range(4, 1);
        span = shadow_cfg.min_step_gap;
        if (span > 40) span = 40;
        span  = span + $urandom_range(10, 0);
        quiet = (span > rise + fall) ? span - rise - fall : 0;
        walk_stride($urandom_range(hi, lo), rise, fall, quiet);
      end else if (kind < 82) begin
        // long enough without a step for walking to lapse into freezing
        quiet = shadow_cfg.freeze_gap;
        if (quiet > 140) quiet = 140;
        walk_stride(0, 0, 0, quiet + $urandom_range(20, 1));
      end else if (kind < 94) begin
        reps = $urandom_range(6, 1);
        repeat (reps) send_sample(SampleW'($urandom), SampleW'($urandom), SampleW'($urandom));
      end else begin
        // equal signal: the same word several times running
        rx   = SampleW'($urandom);
        ry   = SampleW'($urandom);
        rz   = SampleW'($urandom);
        reps = $urandom_range(5, 2);
        repeat (reps) send_sample(rx, ry, rz);
      end
    end
  endtask

  // Half a phase, a full drain by the sender, then the other half.
  task automatic run_phase();
    run_walks(PhaseItems / 2);
    wait_drained();
    run_walks(PhaseItems / 2);
    wait_drained();
  endtask

  initial begin
    shadow_cfg.one_g_level    = OneGLevelRst;
    shadow_cfg.step_threshold = StepThresholdRst;
    shadow_cfg.min_step_gap   = MinStepGapRst;
    shadow_cfg.freeze_gap     = FreezeGapRst;
    shadow_cfg.cadence_factor = CadenceFactorRst;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words at reset settings: extreme axes, all-ones and
    // alternating bit patterns, and an equal signal held for a few words.
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh0000, 16'sh0000);
    send_sample(16'sh0000, 16'sh8000, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000, 16'sh8000);
    send_sample(16'sh4009, 16'sh0000, 16'sh0000);
    send_sample(16'sh4009, 16'sh0000, 16'sh0000);
    send_sample(16'sh4009, 16'sh0000, 16'sh0000);
    send_sample(16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
    send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
    send_sample(16'sh0001, 16'shFFFF, 16'sh0001);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000);
    wait_drained();

    // Short gaps and fast cadence, no idling on either side.
    calm = 1'b1;
    set_config(16'd16384, 16'd2000, 16'd4, 16'd25, 16'd400);
    run_phase();
    calm = 1'b0;

    // Low extremes: zero g level, threshold and gaps, widest cadence.
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    run_phase();

    // High extremes, cadence factor zero: stationary can never turn walking.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    run_phase();

    // Writes past the register list, then the smallest useful cadence.
    write_unknown_reg();
    write_unknown_reg();
    set_config(16'd16393, 16'd3279, 16'd26, 16'd104, 16'd1);
    write_unknown_reg();
    run_phase();

    // Random but sensible settings.
    set_config(CfgW'($urandom_range(20000, 12000)), CfgW'($urandom_range(6000, 200)),
               CfgW'($urandom_range(40, 0)), CfgW'($urandom_range(150, 10)),
               CfgW'($urandom_range(65535, 1)));
    run_phase();

    // Back to the reset values.
    set_config(OneGLevelRst, StepThresholdRst, MinStepGapRst, FreezeGapRst,
               CadenceFactorRst);
    run_phase();

    push = 1'b0;
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
